FILE: rtl/generational_handle_slot_table_assert.svh
// Assertion macros shared by the checker of the slot table.
`ifndef GENERATIONAL_HANDLE_SLOT_TABLE_ASSERT_SVH
`define GENERATIONAL_HANDLE_SLOT_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("slot table assertion failed");

// Next-cycle implication, disabled during reset.
`define GST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("slot table assertion failed");

`endif

FILE: rtl/gst_pkg.sv
// Shared constants of the generational handle slot table.
package gst_pkg;

  localparam int SLOTS_DEFAULT     = 1024;
  localparam int DATA_BITS_DEFAULT = 32;

  localparam logic [1:0] MODE_ADD      = 2'd0;
  localparam logic [1:0] MODE_REMOVE   = 2'd1;
  localparam logic [1:0] MODE_LOOKUP   = 2'd2;
  localparam logic [1:0] MODE_POSITION = 2'd3;

  localparam logic REG_TYPE_CODE    = 1'b0;
  localparam logic REG_TABLE_NUMBER = 1'b1;

  localparam logic [31:0] GEN_STEP = 32'h0001_0000;

endpackage

FILE: rtl/gst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module gst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/generational_handle_slot_table.sv
// Generational handle slot table: a slot map with a packed payload array.
//
// The table hands out 64-bit handles (table number in bits 63..56, object
// type in bits 55..32, slot identifier in bits 31..0) and keeps its payloads
// packed at the front of an array. Each request carries a mode: add takes
// the head of a FIFO free list, bumps the generation in the identifier and
// appends the payload; remove checks the identifier and the live mark, moves
// the last packed entry into the hole and queues the slot at the free-list
// tail; lookup returns the payload of a live handle; the position mode builds
// the handle of a packed entry. Every request yields exactly one result.
// Slot state sits in three RAMs (identifier with live mark, packed position,
// free-list link) and the payloads with their owners in a fourth; all RAM
// reads are registered. An add, a position request and any failing request
// read, then modify and write back; a successful remove or lookup takes a
// further step, since the packed position read from the slot RAM must address
// the packed RAM before the payload is known. Only one request is in flight;
// the next one is taken once the previous one has written its result into
// the output register, even while that result still waits to be taken.
// After reset the slot RAMs are initialized by a clearing pass over every
// slot, during which no request is taken; configuration writes are taken
// at any time.
module generational_handle_slot_table #(
  parameter int SLOTS     = gst_pkg::SLOTS_DEFAULT,
  parameter int DATA_BITS = gst_pkg::DATA_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Request channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [63:0] handle,
  input  logic [31:0] data_in,
  input  logic [15:0] position,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [63:0] handle_out,
  output logic [31:0] data_out,
  output logic [16:0] stored_count
);

  import gst_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int PW = DATA_BITS + 32;
  localparam logic [16:0] SLOTS17 = 17'(SLOTS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC, ST_FIN} state_t;

  state_t state;

  logic [23:0] type_code;
  logic [7:0]  table_number;

  logic [AW-1:0] clr_cnt;
  logic [16:0]   live_total;
  logic [15:0]   free_first;
  logic [15:0]   free_last;

  // Latched request.
  logic [1:0]  req_mode;
  logic [31:0] req_id;
  logic [31:0] req_data;
  logic [15:0] req_pos;

  // Carried from the check cycle to the final cycle of remove and lookup.
  logic [AW-1:0] hole;
  logic [PW-1:0] last_entry;

  // RAM ports.
  logic          ident_we, pos_we, link_we, pk_we;
  logic [AW-1:0] ident_waddr, pos_waddr, link_waddr, pk_waddr;
  logic [32:0]   ident_wdata, ident_rdata;
  logic [15:0]   pos_wdata, pos_rdata, link_wdata, link_rdata;
  logic [PW-1:0] pk_wdata, pk_rdata;
  logic [AW-1:0] slot_raddr, pk_raddr;

  // Request view: ports while idle, latched copy afterwards.
  logic [1:0]  cur_mode;
  logic [31:0] cur_id;
  logic [15:0] cur_pos;
  logic [16:0] lt_m1;

  logic        in_take, out_free, res_load;
  logic        slot_ok, add_ok, rem_ok, pos_ok, mover_ok, last_ok;
  logic [31:0] new_ident;
  logic [31:0] last_owner;
  logic [15:0] mover;

  function automatic logic [63:0] make_handle(input logic [7:0] tbl, input logic [23:0] typ,
                                              input logic [31:0] id);
    make_handle = {tbl, typ, id};
  endfunction

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_TABLE_NUMBER) ? {24'd0, table_number}
                                                   : {8'd0, type_code};
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign cur_mode = (state == ST_IDLE) ? mode : req_mode;
  assign cur_id   = (state == ST_IDLE) ? handle[31:0] : req_id;
  assign cur_pos  = (state == ST_IDLE) ? position : req_pos;
  assign lt_m1    = live_total - 17'd1;

  assign slot_raddr = (cur_mode == MODE_ADD) ? free_first[AW-1:0] : cur_id[AW-1:0];

  // The packed RAM is read at the hole once its position is known, else at the
  // requested position or at the last packed entry.
  always_comb begin
    if (state == ST_FIN) begin
      pk_raddr = hole;
    end else if (state == ST_EXEC && (req_mode == MODE_REMOVE || req_mode == MODE_LOOKUP)) begin
      pk_raddr = pos_rdata[AW-1:0];
    end else if (cur_mode == MODE_POSITION) begin
      pk_raddr = cur_pos[AW-1:0];
    end else begin
      pk_raddr = lt_m1[AW-1:0];
    end
  end

  assign last_owner = pk_rdata[PW-1:DATA_BITS];
  assign mover      = last_owner[15:0];
  assign new_ident  = ident_rdata[31:0] + GEN_STEP;

  assign slot_ok  = ({1'b0, req_id[15:0]} < SLOTS17) && (ident_rdata[31:0] == req_id)
                    && ident_rdata[32];
  assign add_ok   = (live_total < SLOTS17) && ({1'b0, free_first} < SLOTS17);
  assign rem_ok   = slot_ok && (live_total != 17'd0);
  assign pos_ok   = ({1'b0, req_pos} < live_total) && ({1'b0, req_pos} < SLOTS17);
  assign mover_ok = ({1'b0, mover} < SLOTS17);
  assign last_ok  = ({1'b0, free_last} < SLOTS17);

  // A result is loaded into the output register in the last cycle of a request.
  always_comb begin
    res_load = 1'b0;
    if (state == ST_FIN) begin
      res_load = out_free;
    end else if (state == ST_EXEC) begin
      unique case (req_mode)
        MODE_REMOVE: res_load = out_free && !rem_ok;
        MODE_LOOKUP: res_load = out_free && !slot_ok;
        default:     res_load = out_free;
      endcase
    end
  end

  // Write ports: the clearing pass, then the modify step of add and remove,
  // and the hole fill of remove.
  always_comb begin
    ident_we    = 1'b0;
    pos_we      = 1'b0;
    link_we     = 1'b0;
    pk_we       = 1'b0;
    ident_waddr = slot_raddr;
    pos_waddr   = free_first[AW-1:0];
    link_waddr  = free_last[AW-1:0];
    pk_waddr    = live_total[AW-1:0];
    ident_wdata = {1'b1, new_ident};
    pos_wdata   = live_total[15:0];
    link_wdata  = req_id[15:0];
    pk_wdata    = {new_ident, DATA_BITS'(req_data)};
    if (state == ST_CLEAR) begin
      ident_we    = 1'b1;
      pos_we      = 1'b1;
      link_we     = 1'b1;
      ident_waddr = clr_cnt;
      pos_waddr   = clr_cnt;
      link_waddr  = clr_cnt;
      ident_wdata = {1'b0, 32'(clr_cnt)};
      pos_wdata   = 16'd0;
      link_wdata  = 16'({1'b0, clr_cnt} + (AW + 1)'(1));
    end else if (state == ST_EXEC && req_mode == MODE_ADD) begin
      ident_we = add_ok && out_free;
      pos_we   = add_ok && out_free;
      pk_we    = add_ok && out_free;
    end else if (state == ST_EXEC && req_mode == MODE_REMOVE) begin
      ident_we    = rem_ok;
      ident_wdata = {1'b0, ident_rdata[31:0]};
      link_we     = rem_ok && last_ok;
      pos_we      = rem_ok && mover_ok;
      pos_waddr   = mover[AW-1:0];
      pos_wdata   = pos_rdata;
    end else if (state == ST_FIN && req_mode == MODE_REMOVE) begin
      pk_we    = out_free;
      pk_waddr = hole;
      pk_wdata = last_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_cnt      <= '0;
      out_valid    <= 1'b0;
      live_total   <= 17'd0;
      free_first   <= 16'd0;
      free_last    <= 16'(SLOTS - 1);
      type_code    <= 24'd0;
      table_number <= 8'd0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_TYPE_CODE) begin
          type_code <= pwdata[23:0];
        end else begin
          table_number <= pwdata[7:0];
        end
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == LAST_SLOT) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_take) begin
            req_mode <= mode;
            req_id   <= handle[31:0];
            req_data <= data_in;
            req_pos  <= position;
            state    <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          unique case (req_mode)
            MODE_ADD: begin
              if (out_free) begin
                ok           <= add_ok;
                handle_out   <= add_ok ? make_handle(table_number, type_code, new_ident)
                                       : 64'd0;
                data_out     <= 32'd0;
                stored_count <= add_ok ? live_total + 17'd1 : live_total;
                if (add_ok) begin
                  free_first <= link_rdata;
                  live_total <= live_total + 17'd1;
                end
                state <= ST_IDLE;
              end
            end
            MODE_REMOVE: begin
              if (rem_ok) begin
                last_entry <= pk_rdata;
                hole       <= pos_rdata[AW-1:0];
                if (live_total == SLOTS17) begin
                  free_first <= req_id[15:0];
                end
                free_last  <= req_id[15:0];
                live_total <= lt_m1;
                state      <= ST_FIN;
              end else if (out_free) begin
                ok           <= 1'b0;
                handle_out   <= 64'd0;
                data_out     <= 32'd0;
                stored_count <= live_total;
                state        <= ST_IDLE;
              end
            end
            MODE_LOOKUP: begin
              if (slot_ok) begin
                hole  <= pos_rdata[AW-1:0];
                state <= ST_FIN;
              end else if (out_free) begin
                ok           <= 1'b0;
                handle_out   <= 64'd0;
                data_out     <= 32'd0;
                stored_count <= live_total;
                state        <= ST_IDLE;
              end
            end
            MODE_POSITION: begin
              if (out_free) begin
                ok           <= pos_ok;
                handle_out   <= pos_ok ? make_handle(table_number, type_code, last_owner)
                                       : 64'd0;
                data_out     <= 32'd0;
                stored_count <= live_total;
                state        <= ST_IDLE;
              end
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        ST_FIN: begin
          if (out_free) begin
            ok           <= 1'b1;
            handle_out   <= 64'd0;
            data_out     <= 32'(pk_rdata[DATA_BITS-1:0]);
            stored_count <= live_total;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  gst_ram #(.WIDTH(33), .DEPTH(SLOTS)) u_ident_ram (
    .clk(clk), .we(ident_we), .waddr(ident_waddr), .wdata(ident_wdata),
    .raddr(slot_raddr), .rdata(ident_rdata)
  );

  gst_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(slot_raddr), .rdata(pos_rdata)
  );

  gst_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(free_first[AW-1:0]), .rdata(link_rdata)
  );

  gst_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_packed_ram (
    .clk(clk), .we(pk_we), .waddr(pk_waddr), .wdata(pk_wdata),
    .raddr(pk_raddr), .rdata(pk_rdata)
  );

endmodule

FILE: rtl/gst_checker.sv
// Port-level checker for the slot table and its bind statement.
`include "generational_handle_slot_table_assert.svh"

module gst_checker #(
  parameter int SLOTS = gst_pkg::SLOTS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        ok,
  input logic [63:0] handle_out,
  input logic [31:0] data_out,
  input logic [16:0] stored_count
);

  `GST_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(ok) && $stable(handle_out) && $stable(data_out) && $stable(stored_count))
  `GST_ASSERT_NOW(a_fail_zero, out_valid && !ok, handle_out == 64'd0 && data_out == 32'd0)
  `GST_ASSERT_NOW(a_count_range, out_valid, stored_count <= 17'(SLOTS))
  `GST_ASSERT_NOW(a_one_field, out_valid && handle_out != 64'd0, data_out == 32'd0 && ok)

endmodule

bind generational_handle_slot_table gst_checker #(.SLOTS(SLOTS)) u_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall), .ok(ok),
  .handle_out(handle_out), .data_out(data_out), .stored_count(stored_count)
);
